// File: rtl/core/line_edit_input_buffer_unit_defines.svh
// Assertion macros shared by the line edit input buffer RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef LINE_EDIT_INPUT_BUFFER_UNIT_DEFINES_SVH
`define LINE_EDIT_INPUT_BUFFER_UNIT_DEFINES_SVH

// Clocked assertion on clk_i, quiet while rst_ni is low
`define LEIB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define LEIB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/leib_pkg.sv
// Package for the line edit input buffer: sizes, key codes, result type, index helpers.
// No dependencies; used by the top level.
`timescale 1ns / 1ps

package leib_pkg;

  // Store depth and derived widths (indices run modulo 2*DEPTH)
  localparam int DEPTH  = 128;
  localparam int SPAN   = 2 * DEPTH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = $clog2(SPAN);
  localparam int PADDR_W = 3;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [AW-1:0]    addr_t;

  localparam idx_t DEPTH_IX = IDX_W'(DEPTH);
  localparam idx_t SPAN_IX  = IDX_W'(SPAN);
  localparam idx_t LAST_IX  = IDX_W'(SPAN - 1);

  // Opcodes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Key codes
  localparam logic [7:0] KEY_CTRL_C = 8'h03;
  localparam logic [7:0] KEY_CTRL_D = 8'h04;
  localparam logic [7:0] KEY_CTRL_H = 8'h08;
  localparam logic [7:0] KEY_LF     = 8'h0a;
  localparam logic [7:0] KEY_CR     = 8'h0d;
  localparam logic [7:0] KEY_CTRL_P = 8'h10;
  localparam logic [7:0] KEY_CTRL_U = 8'h15;
  localparam logic [7:0] KEY_DEL    = 8'h7f;
  localparam logic [7:0] KEY_NUL    = 8'h00;

  // Read status codes
  localparam logic [1:0] RS_BYTE    = 2'd0;
  localparam logic [1:0] RS_NEWLINE = 2'd1;
  localparam logic [1:0] RS_EOF     = 2'd2;
  localparam logic [1:0] RS_EMPTY   = 2'd3;

  // Register word indexes
  localparam logic [PADDR_W-3:0] REG_LINE_MODE = '0;

  // One result beat
  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       line_ready;
    logic       list_request;
    logic       dropped;
    logic [1:0] read_status;
    logic [7:0] read_char;
  } res_t;

  function automatic idx_t idx_inc(idx_t x);
    return (x == LAST_IX) ? '0 : idx_t'(x + 1'b1);
  endfunction

  function automatic idx_t idx_dec(idx_t x);
    return (x == '0) ? LAST_IX : idx_t'(x - 1'b1);
  endfunction

  // Distance a - b modulo SPAN
  function automatic idx_t idx_dist(idx_t a, idx_t b);
    idx_t diff;
    diff = idx_t'(a - b);
    return (a >= b) ? diff : idx_t'(diff + SPAN_IX);
  endfunction

  // Store slot of an index
  function automatic addr_t idx_slot(idx_t x);
    idx_t s;
    s = (x >= DEPTH_IX) ? idx_t'(x - DEPTH_IX) : x;
    return s[AW-1:0];
  endfunction

  // Clamp an erase count to eight bits
  function automatic logic [7:0] sat_erase(idx_t c);
    logic [IDX_W+7:0] w;
    w = {8'b0, c};
    return (w > (IDX_W+8)'(255)) ? 8'hff : w[7:0];
  endfunction

endpackage

// File: rtl/core/leib_if.sv
// Valid/ready channel interfaces for the line edit input buffer.
// No dependencies; the field widths match the leib_pkg result type.
`timescale 1ns / 1ps

interface leib_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] key;
  logic       read_started;

  modport source (output valid, opcode, key, read_started, input ready);
  modport sink   (input valid, opcode, key, read_started, output ready);
endinterface

interface leib_out_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic [7:0] erase_count;
  logic       line_ready;
  logic       list_request;
  logic       dropped;
  logic [1:0] read_status;
  logic [7:0] read_char;

  modport source (output valid, echo_valid, echo_char, erase_count, line_ready,
                  list_request, dropped, read_status, read_char, input ready);
  modport sink   (input valid, echo_valid, echo_char, erase_count, line_ready,
                  list_request, dropped, read_status, read_char, output ready);
endinterface

// File: rtl/core/line_edit_input_buffer_unit.sv
// Line edit input buffer: keyboard ring store with read, commit and edit indices.
// Depends on leib_pkg, leib_if.sv and line_edit_input_buffer_unit_defines.svh.
//
//  channel  | kind          | beat contents
//  ---------+---------------+-----------------------------------------------
//  in_i     | valid/ready   | opcode, key, read_started
//  out_o    | valid/ready   | echo, erase count, ready/list/drop flags, read
//  apb      | APB write/read| line_mode at byte address 0
//
// Most beats pass through accept, execute and done states; a read of a stored byte adds
// a read state, as the line store has a registered read port.
// A kill-line (^U, ^C) walks back through a fetch and a check state per erased byte;
// at most DEPTH-1 bytes are uncommitted.
// The result sits in an output register; the next beat is taken while it waits,
// and a finished result stalls only if the previous one is still not taken.
// Reset clears the indices and line_mode to 1; the store itself is not cleared.
`timescale 1ns / 1ps
`include "line_edit_input_buffer_unit_defines.svh"

module line_edit_input_buffer_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  leib_in_if.sink                         in_i,
  leib_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [leib_pkg::PADDR_W-1:0]    paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EXEC = 6'b000010,
    ST_RD   = 6'b000100,
    ST_KILL = 6'b001000,
    ST_KCHK = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  leib_pkg::idx_t       read_q, read_d;
  leib_pkg::idx_t       commit_q, commit_d;
  leib_pkg::idx_t       edit_q, edit_d;
  leib_pkg::idx_t       kill_cnt_q, kill_cnt_d;
  logic                 line_mode_q, line_mode_d;
  logic                 op_q;
  logic [7:0]           key_q;
  logic                 started_q;
  leib_pkg::res_t       res_q, res_d;
  leib_pkg::res_t       out_res_q, out_res_d;
  logic                 out_valid_q, out_valid_d;

  logic [7:0]           line_store_q [leib_pkg::DEPTH];
  logic [7:0]           store_rdata_q;
  leib_pkg::addr_t      store_raddr;
  leib_pkg::addr_t      store_waddr;
  logic [7:0]           store_wdata;
  logic                 store_we;

  logic                 in_accept;
  logic                 out_free;
  logic                 cfg_we;
  logic                 reg_hit;
  logic [7:0]           key_char;
  leib_pkg::idx_t       edit_inc;

  // APB port: always ready, one register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[leib_pkg::PADDR_W-1:2] == leib_pkg::REG_LINE_MODE);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? {31'b0, line_mode_q} : 32'b0;
  assign line_mode_d = cfg_we ? pwdata[0] : line_mode_q;

  // Handshakes
  assign out_free  = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) || ((state_q == ST_DONE) && out_free);
  assign in_accept = in_i.valid && in_i.ready;

  // Drive the output beat
  assign out_o.valid        = out_valid_q;
  assign out_o.echo_valid   = out_res_q.echo_valid;
  assign out_o.echo_char    = out_res_q.echo_char;
  assign out_o.erase_count  = out_res_q.erase_count;
  assign out_o.line_ready   = out_res_q.line_ready;
  assign out_o.list_request = out_res_q.list_request;
  assign out_o.dropped      = out_res_q.dropped;
  assign out_o.read_status  = out_res_q.read_status;
  assign out_o.read_char    = out_res_q.read_char;

  assign key_char = (key_q == leib_pkg::KEY_CR) ? leib_pkg::KEY_LF : key_q;
  assign edit_inc = leib_pkg::idx_inc(edit_q);

  // Sequencer: execute, stored-byte read and kill-line walk
  always_comb begin
    state_d     = state_q;
    read_d      = read_q;
    commit_d    = commit_q;
    edit_d      = edit_q;
    kill_cnt_d  = kill_cnt_q;
    res_d       = res_q;
    out_res_d   = out_res_q;
    out_valid_d = out_valid_q && !out_o.ready;
    store_raddr = leib_pkg::idx_slot(read_q);
    store_waddr = leib_pkg::idx_slot(edit_q);
    store_wdata = key_char;
    store_we    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        res_d   = '0;
        state_d = ST_DONE;
        if (op_q == leib_pkg::OP_READ) begin
          if (read_q == commit_q) begin
            res_d.read_status = leib_pkg::RS_EMPTY;
          end else begin
            state_d = ST_RD;
          end
        end else if (key_q == leib_pkg::KEY_CTRL_P) begin
          res_d.list_request = line_mode_q;
        end else if (key_q == leib_pkg::KEY_CTRL_U || key_q == leib_pkg::KEY_CTRL_C) begin
          if (line_mode_q) begin
            kill_cnt_d = '0;
            state_d    = ST_KILL;
          end
        end else if (key_q == leib_pkg::KEY_CTRL_H || key_q == leib_pkg::KEY_DEL) begin
          if (line_mode_q && (edit_q != commit_q)) begin
            edit_d            = leib_pkg::idx_dec(edit_q);
            res_d.erase_count = 8'd1;
          end
        end else if (key_q != leib_pkg::KEY_NUL) begin
          if (leib_pkg::idx_dist(edit_q, read_q) < leib_pkg::DEPTH_IX) begin
            store_we = 1'b1;
            edit_d   = edit_inc;
            if (line_mode_q) begin
              res_d.echo_valid = 1'b1;
              res_d.echo_char  = key_char;
            end
            if (!line_mode_q || key_char == leib_pkg::KEY_LF ||
                key_char == leib_pkg::KEY_CTRL_D ||
                leib_pkg::idx_dist(edit_inc, read_q) == leib_pkg::DEPTH_IX) begin
              commit_d         = edit_inc;
              res_d.line_ready = 1'b1;
            end
          end else begin
            res_d.dropped = 1'b1;
          end
        end
      end

      ST_RD: begin
        // Classify the byte at the read index
        state_d = ST_DONE;
        if (store_rdata_q == leib_pkg::KEY_CTRL_D) begin
          res_d.read_status = leib_pkg::RS_EOF;
          if (!started_q) begin
            read_d = leib_pkg::idx_inc(read_q);
          end
        end else begin
          read_d            = leib_pkg::idx_inc(read_q);
          res_d.read_char   = store_rdata_q;
          res_d.read_status = (store_rdata_q == leib_pkg::KEY_LF) ?
                              leib_pkg::RS_NEWLINE : leib_pkg::RS_BYTE;
        end
      end

      ST_KILL: begin
        // Fetch the byte before the edit index, or stop at the commit index
        store_raddr = leib_pkg::idx_slot(leib_pkg::idx_dec(edit_q));
        if (edit_q == commit_q) begin
          res_d.erase_count = leib_pkg::sat_erase(kill_cnt_q);
          state_d           = ST_DONE;
        end else begin
          state_d = ST_KCHK;
        end
      end

      ST_KCHK: begin
        // Stop at a newline, else erase one byte
        if (store_rdata_q == leib_pkg::KEY_LF) begin
          res_d.erase_count = leib_pkg::sat_erase(kill_cnt_q);
          state_d           = ST_DONE;
        end else begin
          edit_d     = leib_pkg::idx_dec(edit_q);
          kill_cnt_d = leib_pkg::idx_t'(kill_cnt_q + 1'b1);
          state_d    = ST_KILL;
        end
      end

      ST_DONE: begin
        // Hand the result to the output register once it is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = res_q;
          state_d     = in_accept ? ST_EXEC : ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      read_q      <= '0;
      commit_q    <= '0;
      edit_q      <= '0;
      kill_cnt_q  <= '0;
      line_mode_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      read_q      <= read_d;
      commit_q    <= commit_d;
      edit_q      <= edit_d;
      kill_cnt_q  <= kill_cnt_d;
      line_mode_q <= line_mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: input beat and results
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q      <= in_i.opcode;
      key_q     <= in_i.key;
      started_q <= in_i.read_started;
    end
    res_q     <= res_d;
    out_res_q <= out_res_d;
  end

  // Line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      line_store_q[store_waddr] <= store_wdata;
    end
    store_rdata_q <= line_store_q[store_raddr];
  end

  // Index invariants and sequencing checks
  `LEIB_ASSERT(a_fill_bound, (leib_pkg::idx_dist(edit_q, read_q) <= leib_pkg::DEPTH_IX), "edit index ran more than DEPTH ahead of read index")
  `LEIB_ASSERT(a_commit_order, (leib_pkg::idx_dist(commit_q, read_q) <= leib_pkg::idx_dist(edit_q, read_q)), "commit index left the read..edit window")
  `LEIB_ASSERT(a_kill_stop, (state_q == ST_KCHK) |-> (edit_q != commit_q), "kill walk checked a committed byte")
  `LEIB_ASSERT(a_accept_exec, in_accept |=> (state_q == ST_EXEC), "accepted beat did not start execution")
  `LEIB_ASSERT(a_write_exec, store_we |-> (state_q == ST_EXEC && op_q == leib_pkg::OP_KEY), "store written outside a key execute cycle")

endmodule
